// ----- rtl/exponential_backoff_retry_controller_defines.svh -----
// assertion macros for the backoff retry controller
// included by rtl files that carry concurrent assertions, no other dependencies
`ifndef EXPONENTIAL_BACKOFF_RETRY_CONTROLLER_DEFINES_SVH
`define EXPONENTIAL_BACKOFF_RETRY_CONTROLLER_DEFINES_SVH

// same-cycle implication, off during reset
`define EBR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("backoff controller check failed");

// next-cycle implication, off during reset
`define EBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("backoff controller check failed");

`endif

// ----- rtl/ebr_pkg.sv -----
// shared types, codes and widths of the backoff retry controller
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package ebr_pkg;

    // fraction bits of the running delay product
    localparam int FRAC_BITS   = 16;
    localparam int DELAY_W     = 32 + FRAC_BITS;
    // jitter factor k = 2^32 - j*2^16 + j*2r fits in 33 bits
    localparam int K_W         = 33;
    localparam int GROW_W      = 16;
    localparam int GROW_FRAC   = 8;
    localparam int WAIT_W      = 33;
    localparam int CNT_W       = $clog2(K_W + 1);
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [CNT_W-1:0] MUL_LEN_GROW = CNT_W'(GROW_W);
    localparam logic [CNT_W-1:0] MUL_LEN_JIT  = CNT_W'(K_W);

    localparam logic [1:0] OUTCOME_SUCCESS = 2'd0;
    localparam logic [1:0] OUTCOME_RETRY   = 2'd1;

    typedef enum logic [1:0] {
        ACT_DONE    = 2'd0,
        ACT_WAIT    = 2'd1,
        ACT_GAVE_UP = 2'd2,
        ACT_ABORT   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_BASE_DELAY      = 3'd0,
        REG_GROWTH_FACTOR   = 3'd1,
        REG_DELAY_CAP       = 3'd2,
        REG_JITTER_FRACTION = 3'd3,
        REG_ATTEMPT_LIMIT   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] random_fraction;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [32:0] wait_ms;
        logic [15:0] attempts_used;
    } t_out_item;

    typedef struct packed {
        logic [31:0] base_delay;
        logic [15:0] growth_factor;
        logic [31:0] delay_cap;
        logic [15:0] jitter_fraction;
        logic [15:0] attempt_limit;
    } t_cfg;

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] len;
    } t_mul_ctrl;

endpackage

// ----- rtl/ebr_cfg_regs.sv -----
// configuration register file of the backoff retry controller, apb-style port
// depends on ebr_pkg
`timescale 1ns / 1ps

module ebr_cfg_regs import ebr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_delay      <= 32'd100;
            r_cfg.growth_factor   <= 16'd512;
            r_cfg.delay_cap       <= 32'd30000;
            r_cfg.jitter_fraction <= 16'd0;
            r_cfg.attempt_limit   <= 16'd3;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BASE_DELAY:      r_cfg.base_delay      <= pwdata;
                REG_GROWTH_FACTOR:   r_cfg.growth_factor   <= pwdata[15:0];
                REG_DELAY_CAP:       r_cfg.delay_cap       <= pwdata;
                REG_JITTER_FRACTION: r_cfg.jitter_fraction <= pwdata[15:0];
                REG_ATTEMPT_LIMIT:   r_cfg.attempt_limit   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BASE_DELAY:      prdata = r_cfg.base_delay;
            REG_GROWTH_FACTOR:   prdata = {16'd0, r_cfg.growth_factor};
            REG_DELAY_CAP:       prdata = r_cfg.delay_cap;
            REG_JITTER_FRACTION: prdata = {16'd0, r_cfg.jitter_fraction};
            REG_ATTEMPT_LIMIT:   prdata = {16'd0, r_cfg.attempt_limit};
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- rtl/ebr_serial_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on ebr_pkg
`timescale 1ns / 1ps

module ebr_serial_mul import ebr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_ctrl          i_ctrl,
    input  logic [DELAY_W-1:0] i_a,
    input  logic [K_W-1:0]     i_b,
    output logic               o_busy,
    output logic [DELAY_W-1:0] o_hi,
    output logic [K_W-1:0]     o_lo
);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [DELAY_W-1:0] r_a;
    logic [K_W-1:0]     r_b;
    logic [DELAY_W-1:0] r_hi;
    logic [K_W-1:0]     r_lo;
    logic [DELAY_W:0]   sum;

    // partial sum of the upper half, low bit drops into the lower half
    assign sum = {1'b0, r_hi} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.load) begin
            r_busy <= 1'b1;
            r_cnt  <= i_ctrl.len;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_b  <= r_b >> 1;
            r_hi <= sum[DELAY_W:1];
            r_lo <= {sum[0], r_lo[K_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

endmodule

// ----- rtl/exponential_backoff_retry_controller.sv -----
// top level of the capped exponential backoff retry controller
// depends on ebr_pkg, ebr_cfg_regs, ebr_serial_mul and the assertion macro header
`timescale 1ns / 1ps
`include "exponential_backoff_retry_controller_defines.svh"

// Takes one attempt outcome per item (success, retryable failure, permanent
// failure) with a 16-bit random fraction and answers one result item: done,
// wait-then-retry with a jittered delay in ms, gave up, or aborted. The delay
// runs as a fixed-point product with 16 fraction bits, multiplied by
// growth_factor/256 on every retry after the first and held at delay_cap; the
// wait is that delay scaled by 1 + jitter*(2r-1), truncated. Both products go
// through one shared bit-serial multiplier that takes one multiplier bit per
// cycle; the path of an item depends on its action: done, gave up and aborted
// go straight to the finish state, the first retry runs only the 33-bit jitter
// factor product, and later retries first run the 16-bit growth factor product
// and saturate it at delay_cap. One item is in work at a time; o_in_stall is
// high from acceptance until the result has moved into the output register,
// and that register holds a result while the next item is accepted. Any final
// action returns the block to attempt zero. Registers sit on the apb-style
// port at byte address 4*index, pready is always high, and they should be
// written only while no item is in work.

module exponential_backoff_retry_controller import ebr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    // result item channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_KPREP,
        S_JIT,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [15:0]         r_count;
    logic [DELAY_W-1:0]  r_delay;
    logic [K_W-1:0]      r_jr;
    t_action             r_action;
    logic [15:0]         r_used;
    logic [WAIT_W-1:0]   r_wait;
    logic                r_out_valid;
    t_out_item           r_out_item;

    t_cfg                cfg;
    t_mul_ctrl           mul_ctrl;
    logic [DELAY_W-1:0]  mul_a;
    logic [K_W-1:0]      mul_b;
    logic                mul_busy;
    logic [DELAY_W-1:0]  mul_hi;
    logic [K_W-1:0]      mul_lo;

    logic                in_accept;
    logic                out_free;
    logic [16:0]         used;
    logic [16:0]         limit;
    t_action             decision;
    logic [DELAY_W-1:0]  delay_limit;
    logic [DELAY_W-1:0]  first_delay;
    logic [31:0]         first_ms;
    logic [GROW_FRAC-1:0] grow_top;
    logic [DELAY_W-1:0]  grow_low;
    logic [DELAY_W-1:0]  grow_sat;
    logic [K_W:0]        k_sum;

    ebr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ebr_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mul_ctrl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_hi    (mul_hi),
        .o_lo    (mul_lo)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // limit of zero counts as one attempt
    assign used  = {1'b0, r_count} + 17'd1;
    assign limit = (cfg.attempt_limit == 16'd0) ? 17'd1 : {1'b0, cfg.attempt_limit};

    always_comb begin
        if (i_in_item.outcome == OUTCOME_SUCCESS) begin
            decision = ACT_DONE;
        end else if (i_in_item.outcome == OUTCOME_RETRY) begin
            decision = (used >= limit) ? ACT_GAVE_UP : ACT_WAIT;
        end else begin
            // permanent failure and the unused outcome code both abort
            decision = ACT_ABORT;
        end
    end

    // saturation bound and first-retry delay
    assign delay_limit = {cfg.delay_cap, {FRAC_BITS{1'b0}}};
    assign first_ms    = (cfg.base_delay > cfg.delay_cap) ? cfg.delay_cap : cfg.base_delay;
    assign first_delay = {first_ms, {FRAC_BITS{1'b0}}};

    // running product * growth / 256, taken from the serial product
    assign grow_top = mul_hi[DELAY_W-1 -: GROW_FRAC];
    assign grow_low = {mul_hi[DELAY_W-GROW_FRAC-1:0], mul_lo[K_W-1 -: GROW_W-GROW_FRAC]};
    assign grow_sat = ((grow_top != '0) || (grow_low > delay_limit)) ? delay_limit : grow_low;

    // jitter factor 2^32 - j*2^16 + j*2r, always positive
    assign k_sum = (K_W+1)'(64'h1_0000_0000) + {1'b0, r_jr}
                 - (K_W+1)'({cfg.jitter_fraction, 16'd0});

    // shared multiplier: growth step at acceptance, jitter step after it
    always_comb begin
        mul_ctrl.load = 1'b0;
        mul_ctrl.len  = MUL_LEN_GROW;
        mul_a         = r_delay;
        mul_b         = K_W'(cfg.growth_factor);
        if (in_accept && (decision == ACT_WAIT) && (r_count != 16'd0)) begin
            mul_ctrl.load = 1'b1;
        end else if (r_state == S_KPREP) begin
            mul_ctrl.load = 1'b1;
            mul_ctrl.len  = MUL_LEN_JIT;
            mul_b         = k_sum[K_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a finishing item refills the output register in the same cycle
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_action <= decision;
                        r_used   <= used[15:0];
                        r_wait   <= '0;
                        r_jr     <= K_W'(cfg.jitter_fraction)
                                  * K_W'({i_in_item.random_fraction, 1'b0});
                        if (decision != ACT_WAIT) begin
                            r_state <= S_FINISH;
                        end else if (r_count == 16'd0) begin
                            // first retry loads the base delay, capped
                            r_delay <= first_delay;
                            r_state <= S_KPREP;
                        end else begin
                            r_state <= S_GROW;
                        end
                    end
                end
                S_GROW: begin
                    if (!mul_busy) begin
                        r_delay <= grow_sat;
                        r_state <= S_KPREP;
                    end
                end
                S_KPREP: begin
                    r_state <= S_JIT;
                end
                S_JIT: begin
                    if (!mul_busy) begin
                        // drop the 32 + fraction low bits of delay * k
                        r_wait  <= mul_hi[DELAY_W-1 -: WAIT_W];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out_item.action        <= r_action;
                        r_out_item.wait_ms       <= r_wait;
                        r_out_item.attempts_used <= r_used;
                        r_count <= (r_action == ACT_WAIT) ? r_used : 16'd0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // multiplier is quiet whenever the block can take an item
    `EBR_ASSERT_IMPLIES(a_idle_mul_quiet, i_clk, i_rst_n, r_state == S_IDLE, !mul_busy)
    // only a retry carries a delay
    `EBR_ASSERT_IMPLIES(a_wait_only_on_retry, i_clk, i_rst_n, o_out_valid && (o_out_item.action != ACT_WAIT), o_out_item.wait_ms == '0)
    // a final action leaves the block at attempt zero
    `EBR_ASSERT_IMPLIES(a_final_clears_count, i_clk, i_rst_n, o_out_valid && (o_out_item.action != ACT_WAIT), r_count == 16'd0)
    // a retry leaves the count at the attempts reported
    `EBR_ASSERT_IMPLIES(a_retry_keeps_count, i_clk, i_rst_n, o_out_valid && (o_out_item.action == ACT_WAIT), r_count == o_out_item.attempts_used)
    // success skips the multiplier entirely
    `EBR_ASSERT_NEXT(a_success_short_path, i_clk, i_rst_n, in_accept && (i_in_item.outcome == OUTCOME_SUCCESS), r_state == S_FINISH)

endmodule

// ----- verif/tb.sv -----
// testbench for the capped exponential backoff retry controller
// drives attempt outcomes and register writes, predicts every decision and checks it
// depends on ebr_pkg and exponential_backoff_retry_controller
`timescale 1ns / 1ps

module tb;
    import ebr_pkg::*;

    // outcome codes the package leaves unnamed
    localparam logic [1:0] OUTCOME_PERMANENT = 2'd2;
    localparam logic [1:0] OUTCOME_UNUSED    = 2'd3;

    // bound on the whole run, well above what the slowest legal run needs
    localparam int CYCLE_LIMIT  = 1000000;
    // margin left after the last result
    localparam int SETTLE_TAIL  = 60;
    localparam int PHASE_ITEMS  = 75;
    localparam int PHASE_COUNT  = 10;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_item;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    exponential_backoff_retry_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // register shadow, follows every write on the config port
    logic [31:0]        cfg_base;
    logic [15:0]        cfg_growth;
    logic [31:0]        cfg_cap;
    logic [15:0]        cfg_jitter;
    logic [15:0]        cfg_limit;

    // retry state of the predictor
    logic [15:0]        attempt_cnt;
    logic [DELAY_W-1:0] delay_acc;

    // decisions predicted at acceptance, oldest first
    t_out_item          decisions_due[$];
    int                 mismatch_count;
    int                 items_sent;
    int                 cycle_count;
    // when set, neither side inserts gaps or stalls
    bit                 steady_flow;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // gap length: half are zero, most of the rest short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item make_attempt(input logic [1:0] code, input logic [15:0] frac);
        t_in_item it;
        it.outcome         = code;
        it.random_fraction = frac;
        return it;
    endfunction

    // one decision of the backoff controller; updates the retry state as a side effect
    function automatic t_out_item predict_decision(input t_in_item it);
        t_out_item          res;
        logic [16:0]        used;
        logic [16:0]        eff_limit;
        logic [DELAY_W-1:0] ceiling;
        logic [63:0]        grown;
        logic [63:0]        spread;
        logic [95:0]        scaled;
        used          = {1'b0, attempt_cnt} + 17'd1;
        // a zero limit still allows the one attempt already made
        eff_limit     = (cfg_limit == '0) ? 17'd1 : {1'b0, cfg_limit};
        res.wait_ms   = '0;
        res.attempts_used = used[15:0];
        if (it.outcome == OUTCOME_SUCCESS) begin
            res.action = ACT_DONE;
        end else if (it.outcome == OUTCOME_RETRY) begin
            if (used >= eff_limit) begin
                res.action = ACT_GAVE_UP;
            end else begin
                ceiling = DELAY_W'(cfg_cap) << FRAC_BITS;
                // base is only picked up on the first retry of a sequence
                if (attempt_cnt == '0) begin
                    delay_acc = DELAY_W'(cfg_base) << FRAC_BITS;
                end else begin
                    grown = (64'(delay_acc) * 64'(cfg_growth)) >> GROW_FRAC;
                    delay_acc = (grown > 64'(ceiling)) ? ceiling : grown[DELAY_W-1:0];
                end
                if (delay_acc > ceiling)
                    delay_acc = ceiling;
                // jitter factor 1 + j*(2r-1) scaled by 2^32, always positive
                spread = 64'h1_0000_0000 - (64'(cfg_jitter) << 16)
                       + 64'(cfg_jitter) * (64'(it.random_fraction) << 1);
                scaled = 96'(delay_acc) * 96'(spread);
                scaled = scaled >> (32 + FRAC_BITS);
                res.wait_ms = scaled[WAIT_W-1:0];
                res.action  = ACT_WAIT;
            end
        end else begin
            // permanent failure and the unused code both abort
            res.action = ACT_ABORT;
        end
        if (res.action == ACT_WAIT) begin
            attempt_cnt = used[15:0];
        end else begin
            attempt_cnt = '0;
            delay_acc   = '0;
        end
        return res;
    endfunction

    // send one attempt outcome; the decision is predicted at the accepting edge
    task automatic send_attempt(input t_in_item it);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        // valid only drops when a gap follows, so it never toggles within one step
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        decisions_due.push_back(predict_decision(it));
        items_sent++;
    endtask

    // stop sending and wait until every decision is back and the block is idle
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (decisions_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // setup phase, access phase, then an idle phase so psel never toggles in one step
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE_DELAY:      cfg_base   = value;
            REG_GROWTH_FACTOR:   cfg_growth = value[15:0];
            REG_DELAY_CAP:       cfg_cap    = value;
            REG_JITTER_FRACTION: cfg_jitter = value[15:0];
            REG_ATTEMPT_LIMIT:   cfg_limit  = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // result side: random stall runs, none while steady_flow is set
    initial begin : drive_result_stall
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (steady_flow) begin
                hold = 0;
                i_out_stall <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 25)
                    hold = pick_gap();
            end
        end
    end

    // compare every accepted decision with the oldest prediction
    always @(posedge i_clk) begin : check_decisions
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decisions_due.size() == 0) begin
                $display("%0t: unexpected result, actual action %0d wait %0d used %0d",
                         $time, o_out_item.action, o_out_item.wait_ms,
                         o_out_item.attempts_used);
                mismatch_count++;
            end else begin
                want = decisions_due.pop_front();
                if (o_out_item.action !== want.action) begin
                    $display("%0t: action expected %0d actual %0d",
                             $time, want.action, o_out_item.action);
                    mismatch_count++;
                end
                if (o_out_item.wait_ms !== want.wait_ms) begin
                    $display("%0t: wait_ms expected %0d actual %0d",
                             $time, want.wait_ms, o_out_item.wait_ms);
                    mismatch_count++;
                end
                if (o_out_item.attempts_used !== want.attempts_used) begin
                    $display("%0t: attempts_used expected %0d actual %0d",
                             $time, want.attempts_used, o_out_item.attempts_used);
                    mismatch_count++;
                end
            end
        end
    end

    // reset values: base 100, doubling, cap 30000, no jitter, three attempts
    task automatic test_default_schedule();
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h0000));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'hFFFF));
        // third attempt hits the limit
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h1234));
        send_attempt(make_attempt(OUTCOME_SUCCESS, 16'hFFFF));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h8000));
        send_attempt(make_attempt(OUTCOME_SUCCESS, 16'h0000));
    endtask

    // permanent failure and the unused code abort, also mid-sequence
    task automatic test_outcome_codes();
        send_attempt(make_attempt(OUTCOME_PERMANENT, 16'h5555));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'hAAAA));
        send_attempt(make_attempt(OUTCOME_UNUSED, 16'hFFFF));
    endtask

    // zero limit gives up at once; limit lowered and base changed mid-sequence
    task automatic test_limit_changes();
        settle_block();
        write_reg(REG_ATTEMPT_LIMIT, 32'd0);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h0001));
        settle_block();
        write_reg(REG_ATTEMPT_LIMIT, 32'd8);
        write_reg(REG_JITTER_FRACTION, 32'h0000_8000);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h4000));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'hC000));
        // base is only read at attempt zero, so this must not show up yet
        settle_block();
        write_reg(REG_BASE_DELAY, 32'd7);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h2222));
        settle_block();
        write_reg(REG_ATTEMPT_LIMIT, 32'd2);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h3333));
    endtask

    // widest values, and a product that shrinks down from the cap
    task automatic test_field_extremes();
        settle_block();
        write_reg(REG_BASE_DELAY, 32'hFFFF_FFFF);
        write_reg(REG_GROWTH_FACTOR, 32'h0000_FFFF);
        write_reg(REG_DELAY_CAP, 32'hFFFF_FFFF);
        write_reg(REG_JITTER_FRACTION, 32'h0000_FFFF);
        write_reg(REG_ATTEMPT_LIMIT, 32'h0000_FFFF);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h0000));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'hFFFF));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h7FFF));
        send_attempt(make_attempt(OUTCOME_SUCCESS, 16'h0000));
        // base above the cap saturates on load, then growth below one halves it
        settle_block();
        write_reg(REG_DELAY_CAP, 32'd1000);
        write_reg(REG_GROWTH_FACTOR, 32'd128);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'hFFFF));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h0000));
        send_attempt(make_attempt(OUTCOME_RETRY, 16'h8000));
        // zero growth collapses the delay to nothing
        settle_block();
        write_reg(REG_GROWTH_FACTOR, 32'd0);
        send_attempt(make_attempt(OUTCOME_RETRY, 16'hFFFF));
        send_attempt(make_attempt(OUTCOME_PERMANENT, 16'h0000));
    endtask

    function automatic logic [31:0] pick_delay_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 2000);
            1:       return $urandom();
            2:       return $urandom() >> $urandom_range(0, 31);
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    // fresh settings for one random phase; phase 1 all ones, phase 2 all zeros
    task automatic randomize_registers(input int phase);
        logic [31:0] base;
        logic [31:0] cap;
        logic [15:0] growth;
        logic [15:0] jitter;
        logic [15:0] lim;
        base = pick_delay_value();
        cap  = pick_delay_value();
        case ($urandom_range(0, 3))
            0:       growth = 16'($urandom_range(0, 65535));
            1:       growth = 16'($urandom_range(128, 768));
            2:       growth = 16'($urandom_range(256, 1024));
            default: growth = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        endcase
        case ($urandom_range(0, 3))
            0:       jitter = 16'h0;
            1:       jitter = 16'hFFFF;
            default: jitter = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       lim = 16'd0;
            8:       lim = 16'($urandom_range(9, 16));
            9:       lim = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom());
            default: lim = 16'($urandom_range(1, 8));
        endcase
        if (phase == 1) begin
            base = '1; cap = '1; growth = '1; jitter = '1; lim = '1;
        end else if (phase == 2) begin
            base = '0; cap = '0; growth = '0; jitter = '0; lim = '0;
        end
        write_reg(REG_BASE_DELAY, base);
        write_reg(REG_GROWTH_FACTOR, 32'(growth));
        write_reg(REG_DELAY_CAP, cap);
        write_reg(REG_JITTER_FRACTION, 32'(jitter));
        write_reg(REG_ATTEMPT_LIMIT, 32'(lim));
    endtask

    // mostly retry runs closed by a final outcome, some lone random outcomes
    task automatic test_random_backoff();
        int phase;
        int start;
        int retries;
        int eff;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            settle_block();
            randomize_registers(phase);
            // one phase runs with no gaps and no stalls at all
            steady_flow = (phase == 4);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    eff = (cfg_limit == '0) ? 1 : int'(cfg_limit);
                    retries = $urandom_range(0, (eff < 14) ? eff : 14);
                    repeat (retries)
                        send_attempt(make_attempt(OUTCOME_RETRY, 16'($urandom())));
                    case ($urandom_range(0, 9))
                        6, 7:    send_attempt(make_attempt(OUTCOME_PERMANENT,
                                                           16'($urandom())));
                        8:       send_attempt(make_attempt(OUTCOME_UNUSED,
                                                           16'($urandom())));
                        9:       send_attempt(make_attempt(OUTCOME_RETRY,
                                                           16'($urandom())));
                        default: send_attempt(make_attempt(OUTCOME_SUCCESS,
                                                           16'($urandom())));
                    endcase
                end else begin
                    send_attempt(make_attempt(2'($urandom_range(0, 3)), 16'($urandom())));
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        steady_flow    = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        cycle_count    = 0;
        // predictor starts from the reset values of the block
        cfg_base    = 32'd100;
        cfg_growth  = 16'd512;
        cfg_cap     = 32'd30000;
        cfg_jitter  = 16'd0;
        cfg_limit   = 16'd3;
        attempt_cnt = '0;
        delay_acc   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_schedule();
        test_outcome_codes();
        test_limit_changes();
        test_field_extremes();
        test_random_backoff();

        // drain, then give stray results a chance to show up
        settle_block();
        repeat (SETTLE_TAIL) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- exponential_backoff_retry_controller.f -----
+incdir+rtl
rtl/ebr_pkg.sv
rtl/ebr_cfg_regs.sv
rtl/ebr_serial_mul.sv
rtl/exponential_backoff_retry_controller.sv
verif/tb.sv
